FILE: rtl/utf8sd_pkg.sv
// Package for the UTF-8 stream decoder: word types, limits and lead-byte constants.
// Used by every module under rtl/; depends on nothing.
package utf8sd_pkg;

    // Longest string the block is sized for
    localparam int MAX_STRING_BYTES = 65536;

    // Field widths fixed by the interface
    localparam int POS_W = 16;
    localparam int CNT_W = 17;
    localparam int CP_W  = 21;
    localparam int LEN_W = 3;

    // Saturation bounds for byte position and character count
    localparam int POS_CAP_INT = ((MAX_STRING_BYTES - 1) > 65535) ? 65535
                                                                  : (MAX_STRING_BYTES - 1);
    localparam int CNT_CAP_INT = (MAX_STRING_BYTES > 131071) ? 131071 : MAX_STRING_BYTES;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_INT);

    // Lead byte thresholds and payload masks
    localparam logic [7:0] LEAD_2_MIN  = 8'hC0;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD_3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD_4_MIN  = 8'hF0;
    localparam logic [7:0] MASK_LEAD_2 = 8'h1F;
    localparam logic [7:0] MASK_LEAD_3 = 8'h0F;
    localparam logic [7:0] MASK_LEAD_4 = 8'h07;
    localparam logic [7:0] MASK_CONT   = 8'h3F;

    // Sequence lengths
    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

    // Input word: one byte of the string
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } byte_item_t;

    // Output word: one decoded character
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [POS_W-1:0] start_offset;
        logic [LEN_W-1:0] sequence_length;
        logic [CNT_W-1:0] char_ordinal;
        logic             stray_error;
        logic             truncated;
        logic             last_of_string;
    } char_item_t;

endpackage

FILE: rtl/utf8sd_in_stage.sv
// Input register stage of the UTF-8 stream decoder.
// Depends on utf8sd_pkg for the input word type.
module utf8sd_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  utf8sd_pkg::byte_item_t byte_data,
    output logic                   stage_valid,
    input  logic                   stage_take,
    output utf8sd_pkg::byte_item_t stage_item
);

    logic                   valid_reg;
    logic                   valid_next;
    utf8sd_pkg::byte_item_t item_reg;

    // Room when empty or when the held word leaves this cycle
    assign byte_ready  = !valid_reg || stage_take;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        if (byte_valid && byte_ready)
        begin
            valid_next = 1'b1;
        end
        else if (stage_take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            item_reg <= byte_data;
        end
    end

endmodule

FILE: rtl/utf8sd_decode.sv
// Decode step of the UTF-8 stream decoder: sequence state and one-byte update.
// Depends on utf8sd_pkg for types, limits and lead-byte constants.
module utf8sd_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   lax_mode,
    input  logic                   step,
    input  utf8sd_pkg::byte_item_t item,
    output logic                   has_result,
    output utf8sd_pkg::char_item_t result
);

    logic [1:0]                      pending_reg,  pending_next;
    logic [utf8sd_pkg::CP_W-1:0]     acc_reg,      acc_next;
    logic [utf8sd_pkg::LEN_W-1:0]    cur_len_reg,  cur_len_next;
    logic [utf8sd_pkg::POS_W-1:0]    start_reg,    start_next;
    logic [utf8sd_pkg::POS_W-1:0]    pos_reg,      pos_next;
    logic [utf8sd_pkg::CNT_W-1:0]    counter_reg,  counter_next;

    logic [7:0]                      b;
    logic                            last;
    logic [utf8sd_pkg::CNT_W-1:0]    ordinal;
    logic [1:0]                      pend_dec;
    logic [utf8sd_pkg::CP_W-1:0]     acc_shift;

    assign b    = item.data_byte;
    assign last = item.end_of_string;

    // Ordinal of the character this byte would emit, saturating
    assign ordinal = (counter_reg < utf8sd_pkg::CNT_CAP) ? counter_reg + 1'b1 : counter_reg;

    // Continuation byte folded into the accumulator
    assign pend_dec  = pending_reg - 2'd1;
    assign acc_shift = {acc_reg[utf8sd_pkg::CP_W-7:0], b[5:0] & utf8sd_pkg::MASK_CONT[5:0]};

    // One byte of decode
    always_comb
    begin
        pending_next = pending_reg;
        acc_next     = acc_reg;
        cur_len_next = cur_len_reg;
        start_next   = start_reg;
        pos_next     = pos_reg;
        counter_next = counter_reg;
        has_result   = 1'b0;

        result                 = '0;
        result.start_offset    = start_reg;
        result.char_ordinal    = ordinal;
        result.last_of_string  = last;
        result.sequence_length = utf8sd_pkg::LEN_1;

        if (pending_reg == 2'd0)
        begin
            start_next          = pos_reg;
            result.start_offset = pos_reg;
            priority if (b < utf8sd_pkg::ASCII_LIMIT)
            begin
                has_result        = 1'b1;
                result.code_point = utf8sd_pkg::CP_W'(b);
            end
            else if (b < utf8sd_pkg::LEAD_2_MIN)
            begin
                // Stray continuation used as a lead
                has_result         = 1'b1;
                result.code_point  = lax_mode ? utf8sd_pkg::CP_W'(b) : '0;
                result.stray_error = !lax_mode;
            end
            else
            begin
                if (b < utf8sd_pkg::LEAD_3_MIN)
                begin
                    cur_len_next = utf8sd_pkg::LEN_2;
                    acc_next     = utf8sd_pkg::CP_W'(b & utf8sd_pkg::MASK_LEAD_2);
                    pending_next = 2'd1;
                end
                else if (b < utf8sd_pkg::LEAD_4_MIN)
                begin
                    cur_len_next = utf8sd_pkg::LEN_3;
                    acc_next     = utf8sd_pkg::CP_W'(b & utf8sd_pkg::MASK_LEAD_3);
                    pending_next = 2'd2;
                end
                else
                begin
                    cur_len_next = utf8sd_pkg::LEN_4;
                    acc_next     = utf8sd_pkg::CP_W'(b & utf8sd_pkg::MASK_LEAD_4);
                    pending_next = 2'd3;
                end
                // String ends right after a multi-byte lead
                if (last)
                begin
                    has_result       = 1'b1;
                    result.truncated = 1'b1;
                end
            end
        end
        else
        begin
            acc_next     = acc_shift;
            pending_next = pend_dec;
            if (pend_dec == 2'd0)
            begin
                has_result             = 1'b1;
                result.code_point      = acc_shift;
                result.sequence_length = cur_len_reg;
            end
            else if (last)
            begin
                has_result             = 1'b1;
                result.truncated       = 1'b1;
                result.sequence_length = cur_len_reg - {1'b0, pend_dec};
            end
        end

        if (has_result)
        begin
            counter_next = ordinal;
        end

        // End of string clears the per-string state
        if (last)
        begin
            pending_next = 2'd0;
            acc_next     = '0;
            cur_len_next = '0;
            pos_next     = '0;
            counter_next = '0;
        end
        else if (pos_reg < utf8sd_pkg::POS_CAP)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            acc_reg     <= '0;
            cur_len_reg <= '0;
            start_reg   <= '0;
            pos_reg     <= '0;
            counter_reg <= '0;
        end
        else if (step)
        begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
            cur_len_reg <= cur_len_next;
            start_reg   <= start_next;
            pos_reg     <= pos_next;
            counter_reg <= counter_next;
        end
    end

endmodule

FILE: rtl/utf8sd_out_buf.sv
// Two-entry result buffer of the UTF-8 stream decoder; decouples the receiver's stall.
// Depends on utf8sd_pkg for the output word type.
module utf8sd_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  utf8sd_pkg::char_item_t push_item,
    output logic                   full,
    output logic                   char_valid,
    input  logic                   char_ready,
    output utf8sd_pkg::char_item_t char_data
);

    utf8sd_pkg::char_item_t mem [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    assign full       = (count_reg == 2'd2);
    assign char_valid = (count_reg != 2'd0);
    assign char_data  = mem[rd_ptr_reg];
    assign pop        = char_valid && char_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/utf8_stream_decoder_top.sv
// UTF-8 stream decoder, top level.
// Usage:
//   byte channel (byte_valid/byte_ready/byte_data): one string byte per word,
//   end_of_string set on the final byte of each string.
//   char channel (char_valid/char_ready/char_data): one word per decoded
//   character, carrying code point, start offset, length, ordinal and flags.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes lax_mode; always ready.
//   Write it only while no bytes are in flight.
// Path: a byte that finishes a character is held in the input register after
// acceptance, then decoded into the result buffer, where its result appears.
// Throughput: one byte per cycle while the result buffer has room; the decode step
// is a single shift-and-OR between the input register and the two-entry result buffer.
// Stall: while the receiver holds char_ready low, bytes keep flowing until the
// buffer holds two results; then the decode step waits, and byte_ready drops
// once the input register also holds a byte.
// Reset: all decode state, counters and lax_mode clear; both channels empty.
// Depends on utf8sd_pkg, utf8sd_in_stage, utf8sd_decode, utf8sd_out_buf.
module utf8_stream_decoder_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  utf8sd_pkg::byte_item_t byte_data,
    output logic                   char_valid,
    input  logic                   char_ready,
    output utf8sd_pkg::char_item_t char_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);

    logic                   lax_mode_reg;
    logic                   stage_valid;
    logic                   stage_take;
    utf8sd_pkg::byte_item_t stage_item;
    logic                   has_result;
    utf8sd_pkg::char_item_t result;
    logic                   buf_full;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lax_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            lax_mode_reg <= cfg_data;
        end
    end

    // Decode advances when the input register holds a byte and the buffer has room for a result
    assign stage_take = stage_valid && !buf_full;

    utf8sd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_data   (byte_data),
        .stage_valid (stage_valid),
        .stage_take  (stage_take),
        .stage_item  (stage_item)
    );

    utf8sd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .lax_mode   (lax_mode_reg),
        .step       (stage_take),
        .item       (stage_item),
        .has_result (has_result),
        .result     (result)
    );

    utf8sd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (stage_take && has_result),
        .push_item  (result),
        .full       (buf_full),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data)
    );

endmodule
